>>> hdl/adll_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adll_pkg
// types, codes and sizes shared by the linked list core and its parts
// ---------------------------------------------------------------------------
package adll_pkg;

   localparam int SLOTS      = 64;
   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int LINK_BITS  = $clog2(SLOTS + 1);
   localparam int VALUE_BITS = 32;

   typedef logic [LINK_BITS-1:0]  link_type;
   typedef logic [SLOT_BITS-1:0]  slot_type;
   typedef logic [VALUE_BITS-1:0] value_type;

   localparam link_type NULL_LINK = LINK_BITS'(SLOTS);

   // opcodes
   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_DELETE  = 2'd1;
   localparam logic [1:0] OP_LIST_FW = 2'd2;
   localparam logic [1:0] OP_LIST_RV = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] key_value;
   } adll_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [5:0]         slot_index;
      logic signed [31:0] item_value;
      logic               last_flag;
   } adll_rsp_type;

   // link store commands, one read and up to three writes per cycle
   typedef struct packed {
      slot_type  rd_addr;
      logic      val_we;
      value_type val_wdata;
      logic      next_we;
      slot_type  next_waddr;
      link_type  next_wdata;
      logic      prev_we;
      slot_type  prev_waddr;
      link_type  prev_wdata;
   } adll_cmd_type;

   typedef struct packed {
      value_type rd_value;
      link_type  rd_next;
      link_type  rd_prev;
   } adll_data_type;

   function automatic logic link_ok(input link_type link);
      return link < NULL_LINK;
   endfunction

   function automatic slot_type to_slot(input link_type link);
      return link[SLOT_BITS-1:0];
   endfunction

endpackage

>>> hdl/adll_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adll_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module adll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/adll_links.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adll_links
// node value, next link and prev link memories; next links read through
// per-slot valid bits so the reset free chain needs no clearing pass
// ---------------------------------------------------------------------------
module adll_links
   import adll_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  adll_cmd_type  cmd,
   output adll_data_type data
);

   logic [SLOTS-1:0] nvalid_ff, nvalid_in;
   logic             nvalid_rd_ff;
   slot_type         raddr_ff;
   link_type         next_ram;

   adll_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_values (
      .clock (clock),
      .we    (cmd.val_we),
      .waddr (cmd.next_waddr),
      .wdata (cmd.val_wdata),
      .raddr (cmd.rd_addr),
      .rdata (data.rd_value)
   );

   adll_ram #(.WIDTH(LINK_BITS), .DEPTH(SLOTS)) u_next (
      .clock (clock),
      .we    (cmd.next_we),
      .waddr (cmd.next_waddr),
      .wdata (cmd.next_wdata),
      .raddr (cmd.rd_addr),
      .rdata (next_ram)
   );

   // prev links of linked nodes are always written before they are read
   adll_ram #(.WIDTH(LINK_BITS), .DEPTH(SLOTS)) u_prev (
      .clock (clock),
      .we    (cmd.prev_we),
      .waddr (cmd.prev_waddr),
      .wdata (cmd.prev_wdata),
      .raddr (cmd.rd_addr),
      .rdata (data.rd_prev)
   );

   always_comb begin
      nvalid_in = nvalid_ff;
      if (cmd.next_we) begin
         nvalid_in[cmd.next_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nvalid_ff <= '0;
      end else begin
         nvalid_ff <= nvalid_in;
      end
      nvalid_rd_ff <= nvalid_ff[cmd.rd_addr];
      raddr_ff     <= cmd.rd_addr;
   end

   // unwritten entry: slot i links to i+1, last slot to null
   assign data.rd_next = nvalid_rd_ff ? next_ram
                                      : LINK_BITS'(raddr_ff) + LINK_BITS'(1);

endmodule

>>> hdl/adll_seq.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adll_seq
// sequencer: walks links one read per cycle unless stalled; patches them
// ---------------------------------------------------------------------------
module adll_seq
   import adll_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  adll_req_type  req_data,
   input  logic          out_room,
   output logic          out_load,
   output adll_rsp_type  out_beat,
   output adll_cmd_type  cmd,
   input  adll_data_type data
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_INS_LINK = 4'd1;
   localparam logic [3:0] S_INS_TAIL = 4'd2;
   localparam logic [3:0] S_DEL_CMP  = 4'd3;
   localparam logic [3:0] S_DEL_FIX1 = 4'd4;
   localparam logic [3:0] S_DEL_FIX2 = 4'd5;
   localparam logic [3:0] S_LIST     = 4'd6;
   localparam logic [3:0] S_RESP     = 4'd7;

   logic [3:0]         state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic signed [31:0] key_ff, key_in;
   link_type           head_ff, head_in;
   link_type           tail_ff, tail_in;
   link_type           free_ff, free_in;
   link_type           cur_ff, cur_in;
   link_type           nx_ff, nx_in;
   link_type           pv_ff, pv_in;
   logic [1:0]         status_ff, status_in;
   link_type           walk_nxt;
   logic               accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign walk_nxt  = (op_ff == OP_LIST_RV) ? data.rd_prev : data.rd_next;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      free_in   = free_ff;
      cur_in    = cur_ff;
      nx_in     = nx_ff;
      pv_in     = pv_ff;
      status_in = status_ff;

      cmd            = '0;
      cmd.rd_addr    = to_slot(cur_ff);
      cmd.val_wdata  = VALUE_BITS'(key_ff);

      out_load            = 1'b0;
      out_beat.status     = status_ff;
      out_beat.slot_index = (status_ff == ST_OK) ? 6'(cur_ff) : 6'd0;
      out_beat.item_value = key_ff;
      out_beat.last_flag  = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in  = req_data.opcode;
               key_in = req_data.key_value;
               unique case (req_data.opcode)
                  OP_INSERT: begin
                     if (!link_ok(free_ff)) begin
                        status_in = ST_FULL;
                        state_in  = S_RESP;
                     end else begin
                        cmd.rd_addr = to_slot(free_ff);
                        cur_in      = free_ff;
                        state_in    = S_INS_LINK;
                     end
                  end
                  OP_DELETE: begin
                     if (!link_ok(head_ff)) begin
                        status_in = ST_NOT_FOUND;
                        state_in  = S_RESP;
                     end else begin
                        cmd.rd_addr = to_slot(head_ff);
                        cur_in      = head_ff;
                        state_in    = S_DEL_CMP;
                     end
                  end
                  default: begin
                     if (!link_ok(head_ff)) begin
                        status_in = ST_EMPTY;
                        state_in  = S_RESP;
                     end else begin
                        cur_in      = (req_data.opcode == OP_LIST_RV) ? tail_ff : head_ff;
                        cmd.rd_addr = to_slot(cur_in);
                        status_in   = ST_OK;
                        state_in    = S_LIST;
                     end
                  end
               endcase
            end
         end
         S_INS_LINK: begin
            // pop the free chain, new node links back to the old tail
            free_in        = data.rd_next;
            cmd.val_we     = 1'b1;
            cmd.next_we    = 1'b1;
            cmd.next_waddr = to_slot(cur_ff);
            cmd.next_wdata = NULL_LINK;
            cmd.prev_we    = 1'b1;
            cmd.prev_waddr = to_slot(cur_ff);
            cmd.prev_wdata = tail_ff;
            status_in      = ST_OK;
            if (link_ok(tail_ff)) begin
               state_in = S_INS_TAIL;
            end else begin
               head_in  = cur_ff;
               tail_in  = cur_ff;
               state_in = S_RESP;
            end
         end
         S_INS_TAIL: begin
            cmd.next_we    = 1'b1;
            cmd.next_waddr = to_slot(tail_ff);
            cmd.next_wdata = cur_ff;
            tail_in        = cur_ff;
            state_in       = S_RESP;
         end
         S_DEL_CMP: begin
            if (data.rd_value == VALUE_BITS'(key_ff)) begin
               nx_in    = data.rd_next;
               pv_in    = data.rd_prev;
               state_in = S_DEL_FIX1;
            end else if (!link_ok(data.rd_next)) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_RESP;
            end else begin
               cmd.rd_addr = to_slot(data.rd_next);
               cur_in      = data.rd_next;
            end
         end
         S_DEL_FIX1: begin
            // freed slot goes to the front of the free chain
            cmd.next_we    = 1'b1;
            cmd.next_waddr = to_slot(cur_ff);
            cmd.next_wdata = free_ff;
            cmd.prev_we    = link_ok(nx_ff);
            cmd.prev_waddr = to_slot(nx_ff);
            cmd.prev_wdata = link_ok(pv_ff) ? pv_ff : NULL_LINK;
            free_in        = cur_ff;
            if (cur_ff == head_ff) begin
               head_in = link_ok(nx_ff) ? nx_ff : NULL_LINK;
            end
            if (cur_ff == tail_ff) begin
               tail_in = link_ok(pv_ff) ? pv_ff : NULL_LINK;
            end
            state_in = S_DEL_FIX2;
         end
         S_DEL_FIX2: begin
            cmd.next_we    = link_ok(pv_ff);
            cmd.next_waddr = to_slot(pv_ff);
            cmd.next_wdata = link_ok(nx_ff) ? nx_ff : NULL_LINK;
            cmd.prev_we    = 1'b1;
            cmd.prev_waddr = to_slot(cur_ff);
            cmd.prev_wdata = NULL_LINK;
            status_in      = ST_OK;
            state_in       = S_RESP;
         end
         S_LIST: begin
            out_beat.status     = ST_OK;
            out_beat.slot_index = 6'(cur_ff);
            out_beat.item_value = 32'($signed(data.rd_value));
            out_beat.last_flag  = !link_ok(walk_nxt);
            if (out_room) begin
               out_load = 1'b1;
               if (!link_ok(walk_nxt)) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_addr = to_slot(walk_nxt);
                  cur_in      = walk_nxt;
               end
            end
         end
         S_RESP: begin
            if (out_room) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= NULL_LINK;
         tail_ff  <= NULL_LINK;
         free_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         free_ff  <= free_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      cur_ff    <= cur_in;
      nx_ff     <= nx_in;
      pv_ff     <= pv_in;
      status_ff <= status_in;
   end

endmodule

>>> hdl/array_doubly_linked_list_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// array_doubly_linked_list_core
// doubly linked list kept in a fixed slot pool with a free chain
// ---------------------------------------------------------------------------
//  channel   ports                          beat
//  request   req_valid req_ready req_data   opcode, key_value
//  response  rsp_valid rsp_ready rsp_data   status, slot_index, item_value,
//                                           last_flag
//
// - insert: free chain pop, then link writes; the tail is kept in
//   a register so no walk is needed
// - delete: walks from the head with one read of the shared memory port
//   per node visited, patches the links in S_DEL_FIX1 and then S_DEL_FIX2,
//   and loads the beat
// - listing: one beat per node per cycle while the output has room, set by the single memory read port
// - reset clears head, tail, free pointer and next-link valid bits; no clearing pass
// - req_ready is high only while idle; a stalled rsp holds the walk in place
//   while the last beat waits in the output register
// ---------------------------------------------------------------------------
module array_doubly_linked_list_core
   import adll_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  adll_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output adll_rsp_type rsp_data
);

   adll_cmd_type  cmd;
   adll_data_type data;
   adll_rsp_type  out_beat;
   logic          out_load;
   logic          out_room;

   logic          rsp_valid_ff, rsp_valid_in;
   adll_rsp_type  rsp_data_ff, rsp_data_in;

   // walk sequencer and list pointers
   adll_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_room  (out_room),
      .out_load  (out_load),
      .out_beat  (out_beat),
      .cmd       (cmd),
      .data      (data)
   );

   // node storage
   adll_links u_links (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .data  (data)
   );

   // output register, free when empty or being taken this cycle
   assign out_room = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = out_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
